// ===== rtl/tfsp_pkg.sv =====
// package for the tagged fifo sample pairer
// holds field widths, the default pairs per batch, tag reset codes and register indices; no dependencies

package tfsp_pkg;

  localparam int TagW      = 5;
  localparam int TagByteW  = 8;
  localparam int PayloadW  = 48;
  localparam int StampW    = 32;
  localparam int AxisW     = 16;
  localparam int CfgIdxW   = 1;

  localparam int PairsPerBatchDef = 10;

  localparam logic [TagW-1:0] AccelTagRst = 5'h02;
  localparam logic [TagW-1:0] StampTagRst = 5'h04;

  typedef enum logic [CfgIdxW-1:0] {
    CfgAccelTag = 1'b0,
    CfgStampTag = 1'b1
  } cfg_reg_e;

endpackage

// ===== rtl/tfsp_in_if.sv =====
// input channel carrying one tagged fifo word per transaction
// depends on tfsp_pkg

interface tfsp_in_if import tfsp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [TagByteW-1:0] tag_byte;
  logic [PayloadW-1:0] payload;
  logic                batch_start;

  modport source (output valid, tag_byte, payload, batch_start, input ready);
  modport sink   (input valid, tag_byte, payload, batch_start, output ready);
endinterface

// ===== rtl/tfsp_out_if.sv =====
// output channel carrying one paired sample per transaction
// depends on tfsp_pkg

interface tfsp_out_if import tfsp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic        [StampW-1:0] stamp;
  logic signed [AxisW-1:0]  accel_x;
  logic signed [AxisW-1:0]  accel_y;
  logic signed [AxisW-1:0]  accel_z;

  modport source (output valid, stamp, accel_x, accel_y, accel_z, input ready);
  modport sink   (input valid, stamp, accel_x, accel_y, accel_z, output ready);
endinterface

// ===== rtl/tfsp_cfg_if.sv =====
// configuration write channel: register index and write data
// depends on tfsp_pkg

interface tfsp_cfg_if import tfsp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [TagW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/tagged_fifo_sample_pairer_unit.sv =====
// tagged fifo word parser pairing accelerometer and timestamp words
// depends on tfsp_pkg, tfsp_in_if, tfsp_out_if, tfsp_cfg_if
// a pair with a nonzero stamp is registered, valid the cycle after its last word
// one word per cycle unless a held output waits; it frees when the sink takes it
// reset: tags return to 2 and 4, pairing flags, pair count and output valid clear

module tagged_fifo_sample_pairer_unit import tfsp_pkg::*; #(
  parameter int PAIRS_PER_BATCH = PairsPerBatchDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tfsp_in_if.sink     in_i,
  tfsp_cfg_if.sink    cfg_i,
  tfsp_out_if.source  out_o
);

  localparam int CntW = $clog2(PAIRS_PER_BATCH + 1);
  localparam logic [CntW-1:0] CntCap = CntW'(PAIRS_PER_BATCH);

  logic [TagW-1:0]     accel_tag_q, stamp_tag_q;
  logic                have_accel_q, have_accel_d;
  logic                have_stamp_q, have_stamp_d;
  logic [CntW-1:0]     pairs_q, pairs_d, cnt;
  logic [PayloadW-1:0] held_axes_q, axes;
  logic [StampW-1:0]   held_stamp_q, stamp;
  logic [TagW-1:0]     tag;
  logic                is_accel, is_stamp, have_a, have_s, pair, emit, accept;
  logic                out_valid_q;
  logic [StampW-1:0]   out_stamp_q;
  logic [PayloadW-1:0] out_axes_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_tag_q <= AccelTagRst;
      stamp_tag_q <= StampTagRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        CfgAccelTag: accel_tag_q <= cfg_i.data;
        CfgStampTag: stamp_tag_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // word decode and pairing
  assign tag      = in_i.tag_byte[TagByteW-1 -: TagW];
  assign is_accel = (tag == accel_tag_q);
  assign is_stamp = !is_accel && (tag == stamp_tag_q);
  assign have_a   = is_accel || (have_accel_q && !in_i.batch_start);
  assign have_s   = is_stamp || (have_stamp_q && !in_i.batch_start);
  assign cnt      = in_i.batch_start ? '0 : pairs_q;
  assign axes     = is_accel ? in_i.payload : held_axes_q;
  assign stamp    = is_stamp ? in_i.payload[StampW-1:0] : held_stamp_q;
  assign pair     = have_a && have_s && (cnt < CntCap);
  assign emit     = pair && (stamp != '0);

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    have_accel_d = have_a && !pair;
    have_stamp_d = have_s && !pair;
    pairs_d      = pair ? cnt + 1'b1 : cnt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_accel_q <= 1'b0;
      have_stamp_q <= 1'b0;
      pairs_q      <= '0;
    end else if (accept) begin
      have_accel_q <= have_accel_d;
      have_stamp_q <= have_stamp_d;
      pairs_q      <= pairs_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      held_axes_q  <= axes;
      held_stamp_q <= stamp;
    end
    if (accept && emit) begin
      out_stamp_q <= stamp;
      out_axes_q  <= axes;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.stamp   = out_stamp_q;
  assign out_o.accel_x = out_axes_q[AxisW-1:0];
  assign out_o.accel_y = out_axes_q[2*AxisW-1:AxisW];
  assign out_o.accel_z = out_axes_q[3*AxisW-1:2*AxisW];

  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pairs_q <= CntCap)
    else $error("pair count above cap");

  a_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && emit |=> out_valid_q)
    else $error("sample lost");

  a_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_stamp_q != '0)
    else $error("zero stamp emitted");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && pair |=> !have_accel_q && !have_stamp_q)
    else $error("flags not cleared after pair");

endmodule
